// ===== hdl/pcwa_pkg.sv =====
// ----------------------------------------------------------------------------
// pcwa_pkg
// Shared widths, codes and types for the per-channel window average alarm.
// ----------------------------------------------------------------------------
package pcwa_pkg;

    localparam int NODE_ID_W = 10;
    localparam int TEMP_W    = 16;
    localparam int ALARM_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [ALARM_W-1:0] ALARM_NORMAL = 2'd0;
    localparam logic [ALARM_W-1:0] ALARM_COLD   = 2'd1;
    localparam logic [ALARM_W-1:0] ALARM_HOT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLD_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD  = 2'd1;

    localparam logic signed [TEMP_W-1:0] COLD_RESET = 16'sd1280;
    localparam logic signed [TEMP_W-1:0] HOT_RESET  = 16'sd7680;

    typedef struct packed {
        logic [NODE_ID_W-1:0]     node;
        logic signed [TEMP_W-1:0] temp;
        logic                     in_range;
    } t_item;

endpackage

// ===== hdl/pcwa_if.sv =====
// ----------------------------------------------------------------------------
// pcwa interfaces
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface pcwa_in_if import pcwa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [NODE_ID_W-1:0]     node_id;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output node_id, output temperature, input ready);
    modport sink   (input valid, input node_id, input temperature, output ready);
endinterface

interface pcwa_out_if import pcwa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [NODE_ID_W-1:0]     node_out;
    logic signed [TEMP_W-1:0] average;
    logic [ALARM_W-1:0]       alarm;

    modport source (output valid, output node_out, output average, output alarm,
                    input ready);
    modport sink   (input valid, input node_out, input average, input alarm,
                    output ready);
endinterface

interface pcwa_cfg_if import pcwa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TEMP_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pcwa_front.sv =====
// ----------------------------------------------------------------------------
// pcwa_front
// Takes sample words, tags each with its node range check, pushes to queue.
// ----------------------------------------------------------------------------
module pcwa_front import pcwa_pkg::*; #(
    parameter int NODE_COUNT = 1024
) (
    pcwa_in_if.sink i_in,
    input  logic    i_clear_busy,
    input  logic    i_full,
    output logic    o_push,
    output t_item   o_item
);

    localparam logic [12:0] NODE_LIMIT = 13'(NODE_COUNT);

    assign i_in.ready       = !i_full && !i_clear_busy;
    assign o_push           = i_in.valid && i_in.ready;
    assign o_item.node      = i_in.node_id;
    assign o_item.temp      = i_in.temperature;
    assign o_item.in_range  = (13'(i_in.node_id) < NODE_LIMIT);

endmodule

// ===== hdl/pcwa_queue.sv =====
// ----------------------------------------------------------------------------
// pcwa_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module pcwa_queue import pcwa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/pcwa_back.sv =====
// ----------------------------------------------------------------------------
// pcwa_back
// Per-node ring update, bit-serial average divide, threshold compare, result.
// ----------------------------------------------------------------------------
module pcwa_back import pcwa_pkg::*; #(
    parameter int NODE_COUNT = 1024,
    parameter int WINDOW     = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcwa_cfg_if.sink    i_cfg,
    input  t_item       i_item,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_clear_busy,
    pcwa_out_if.source  o_out
);

    localparam int NODE_LIM  = 1 << NODE_ID_W;
    localparam int NODES     = (NODE_COUNT < NODE_LIM) ? NODE_COUNT : NODE_LIM;
    localparam int NODE_AW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = TEMP_W + 1 + POS_W;
    localparam int ENT_W     = SUM_W + POS_W + CNT_W;
    localparam int SAMP_D    = NODES * WINDOW;
    localparam int SAMP_AW   = (SAMP_D > 1) ? $clog2(SAMP_D) : 1;
    localparam int STEP_W    = $clog2(SUM_W + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RDN   = 3'd2;
    localparam logic [2:0] ST_RDS   = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    // node entry: {sum, pos, count}
    logic [ENT_W-1:0]          r_node_mem [NODES];
    logic [TEMP_W-1:0]         r_samp_mem [SAMP_D];

    logic [2:0]                r_state;
    logic [NODE_AW-1:0]        r_clr_addr;
    logic [NODE_ID_W-1:0]      r_node;
    logic signed [TEMP_W-1:0]  r_temp;
    logic                      r_inr;
    logic [ENT_W-1:0]          r_node_rd;
    logic [SAMP_AW-1:0]        r_slot;
    logic signed [TEMP_W-1:0]  r_samp_rd;
    logic [SUM_W-1:0]          r_sum;
    logic [POS_W-1:0]          r_pos;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_neg;
    logic [SUM_W-1:0]          r_quo;
    logic [CNT_W-1:0]          r_rem;
    logic [CNT_W-1:0]          r_divisor;
    logic [STEP_W-1:0]         r_step;
    logic signed [TEMP_W-1:0]  r_cold;
    logic signed [TEMP_W-1:0]  r_hot;
    logic                      r_out_valid;
    logic [NODE_ID_W-1:0]      r_out_node;
    logic signed [TEMP_W-1:0]  r_out_avg;
    logic [ALARM_W-1:0]        r_out_alarm;

    logic                      node_we;
    logic [NODE_AW-1:0]        node_waddr;
    logic [ENT_W-1:0]          node_wdata;
    logic [SAMP_AW:0]          slot_full;
    logic                      win_full;
    logic [SUM_W-1:0]          n_sum;
    logic [CNT_W-1:0]          n_cnt;
    logic [POS_W-1:0]          n_pos;
    logic [SUM_W-1:0]          n_mag;
    logic [CNT_W:0]            rem_sh;
    logic                      ge;
    logic [SUM_W-1:0]          quo_signed;
    logic signed [TEMP_W-1:0]  n_avg;
    logic [ALARM_W-1:0]        n_alarm;
    logic                      out_free;

    assign o_clear_busy = (r_state == ST_CLEAR);
    assign o_pop        = (r_state == ST_IDLE) && !i_empty;
    assign out_free     = !r_out_valid || o_out.ready;

    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.node_out  = r_out_node;
    assign o_out.average   = r_out_avg;
    assign o_out.alarm     = r_out_alarm;

    // slot address of the node's ring entry
    assign slot_full = (SAMP_AW + 1)'(r_node[NODE_AW-1:0]) * (SAMP_AW + 1)'(WINDOW)
                     + (SAMP_AW + 1)'(r_node_rd[CNT_W +: POS_W]);

    // window update
    always_comb begin
        win_full = (r_cnt >= CNT_W'(WINDOW));
        n_sum    = r_sum + {{(SUM_W-TEMP_W){r_temp[TEMP_W-1]}}, r_temp};
        if (win_full) begin
            n_sum = n_sum - {{(SUM_W-TEMP_W){r_samp_rd[TEMP_W-1]}}, r_samp_rd};
            n_cnt = CNT_W'(WINDOW);
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (r_pos == POS_W'(WINDOW - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
        n_mag = n_sum[SUM_W-1] ? (~n_sum + SUM_W'(1)) : n_sum;
    end

    // one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_divisor});

    always_comb begin
        quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
        n_avg      = r_inr ? quo_signed[TEMP_W-1:0] : '0;
        if (!r_inr) begin
            n_alarm = ALARM_NORMAL;
        end else if (n_avg <= r_cold) begin
            n_alarm = ALARM_COLD;
        end else if (n_avg >= r_hot) begin
            n_alarm = ALARM_HOT;
        end else begin
            n_alarm = ALARM_NORMAL;
        end
    end

    always_comb begin
        node_we    = 1'b0;
        node_waddr = r_clr_addr;
        node_wdata = '0;
        if (r_state == ST_CLEAR) begin
            node_we = 1'b1;
        end else if (r_state == ST_UPD) begin
            node_we    = 1'b1;
            node_waddr = r_node[NODE_AW-1:0];
            node_wdata = {n_sum, n_pos, n_cnt};
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_waddr] <= node_wdata;
        end
        if (o_pop) begin
            r_node_rd <= r_node_mem[i_item.node[NODE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_samp_mem[r_slot] <= r_temp;
        end
        if (r_state == ST_RDS) begin
            r_samp_rd <= r_samp_mem[r_slot];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_node <= i_item.node;
                r_temp <= i_item.temp;
                r_inr  <= i_item.in_range;
            end
            ST_RDN: begin
                r_slot <= slot_full[SAMP_AW-1:0];
                r_sum  <= r_node_rd[CNT_W+POS_W +: SUM_W];
                r_pos  <= r_node_rd[CNT_W +: POS_W];
                r_cnt  <= r_node_rd[CNT_W-1:0];
            end
            ST_UPD: begin
                r_neg     <= n_sum[SUM_W-1];
                r_quo     <= n_mag;
                r_rem     <= '0;
                r_divisor <= n_cnt;
                r_step    <= '0;
            end
            ST_DIV: begin
                r_rem  <= ge ? CNT_W'(rem_sh - {1'b0, r_divisor}) : rem_sh[CNT_W-1:0];
                r_quo  <= {r_quo[SUM_W-2:0], ge};
                r_step <= r_step + STEP_W'(1);
            end
            default: begin
            end
        endcase
        if ((r_state == ST_FIN) && out_free) begin
            r_out_node  <= r_node;
            r_out_avg   <= n_avg;
            r_out_alarm <= n_alarm;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_cold      <= COLD_RESET;
            r_hot       <= HOT_RESET;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_COLD_THRESHOLD) begin
                    r_cold <= i_cfg.data;
                end else if (i_cfg.index == CFG_HOT_THRESHOLD) begin
                    r_hot <= i_cfg.data;
                end
            end
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + NODE_AW'(1);
                    if (r_clr_addr == NODE_AW'(NODES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= i_item.in_range ? ST_RDN : ST_FIN;
                    end
                end
                ST_RDN:  r_state <= ST_RDS;
                ST_RDS:  r_state <= ST_UPD;
                ST_UPD:  r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_pop)
        else $error("queue popped during clearing pass");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_divisor != '0))
        else $error("divide by zero count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (n_cnt <= CNT_W'(WINDOW)))
        else $error("sample count above window");

    a_fin_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_step == STEP_W'(SUM_W - 1))) |=> (r_state == ST_FIN))
        else $error("divide did not finish");
`endif

endmodule

// ===== hdl/per_channel_window_average_alarm.sv =====
// ----------------------------------------------------------------------------
// per_channel_window_average_alarm
// Per-node moving average of Q8.8 temperatures with cold/hot alarm.
// ----------------------------------------------------------------------------
// Each sample word (node, temperature) yields one result word with the node's
// average over its last WINDOW samples (all of them while fewer), truncated
// toward zero, and an alarm code (0 normal, 1 cold, 2 hot; cold wins). Nodes
// at or above NODE_COUNT leave state untouched and report average 0, normal.
// An in-range word passes node read, sample read, update, a one-bit-per-cycle
// divide of the running sum by the count, and finish; an out-of-range word goes
// straight to finish. A two-word queue lets input be taken while a result waits.
// After reset a clearing pass over min(NODE_COUNT, 1024) node entries zeroes the
// node table; no samples are taken meanwhile, register writes are.
module per_channel_window_average_alarm import pcwa_pkg::*; #(
    parameter int NODE_COUNT = 1024,
    parameter int WINDOW     = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcwa_in_if.sink     i_in,
    pcwa_cfg_if.sink    i_cfg,
    pcwa_out_if.source  o_out
);

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    logic  clear_busy;
    t_item front_item;
    t_item queue_item;

    pcwa_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .i_in         (i_in),
        .i_clear_busy (clear_busy),
        .i_full       (full),
        .o_push       (push),
        .o_item       (front_item)
    );

    pcwa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_full  (full),
        .o_empty (empty)
    );

    pcwa_back #(
        .NODE_COUNT (NODE_COUNT),
        .WINDOW     (WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_item       (queue_item),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_clear_busy (clear_busy),
        .o_out        (o_out)
    );

endmodule
